[hw/rtl/ubsd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; imported by every module of the block.
package ubsd_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 2;
    localparam int CNT_W  = 2;

    localparam logic [CP_W-1:0] REPL_RESET = 21'd32;

    // Upper bounds of the byte classes
    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7f;
    localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hbf;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hf7;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    // Results produced by one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CP_W-1:0]  cp0;
        logic [CP_W-1:0]  cp1;
    } t_dec_res;

endpackage

[hw/rtl/ubsd_in_if.sv]
`timescale 1ns / 1ps
// Byte input channel: valid/ready handshake with one UTF-8 byte per item.
// Depends on ubsd_pkg for widths.
interface ubsd_in_if import ubsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              end_of_text;

    modport source (output valid, output byte_value, output end_of_text, input ready);
    modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

[hw/rtl/ubsd_out_if.sv]
`timescale 1ns / 1ps
// Code point output channel: valid/ready handshake with one code point per item.
// Depends on ubsd_pkg for widths.
interface ubsd_out_if import ubsd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            last_of_run;

    modport source (output valid, output code_point, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

[hw/rtl/ubsd_decoder.sv]
`timescale 1ns / 1ps
// Byte classifier and sequence state (pending count, accumulator).
// Produces up to two code points per accepted byte; uses ubsd_pkg.
module ubsd_decoder import ubsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte_value,
    input  logic              i_end_of_text,
    input  logic [CP_W-1:0]   i_repl,
    output t_dec_res          o_res,
    output logic              o_pend_idle
);

    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;
    logic [CP_W-1:0]   r_acc;
    logic [CP_W-1:0]   n_acc;

    always_comb begin
        logic [CP_W-1:0] acc_sh;
        acc_sh = {r_acc[CP_W-7:0], i_byte_value[5:0]};
        n_pend = r_pend;
        n_acc  = r_acc;
        o_res  = '0;

        if (i_byte_value <= ASCII_MAX) begin
            if (r_pend != PEND_NONE) begin
                o_res.cp0   = i_repl;
                o_res.cp1   = {{(CP_W-BYTE_W){1'b0}}, i_byte_value};
                o_res.count = 2'd2;
                n_pend      = PEND_NONE;
            end else begin
                o_res.cp0   = {{(CP_W-BYTE_W){1'b0}}, i_byte_value};
                o_res.count = 2'd1;
            end
        end else if (i_byte_value <= CONT_MAX) begin
            if (r_pend != PEND_NONE) begin
                n_acc  = acc_sh;
                n_pend = r_pend - PEND_ONE;
                if (n_pend == PEND_NONE) begin
                    o_res.cp0   = acc_sh;
                    o_res.count = 2'd1;
                end
            end else begin
                // stray continuation
                o_res.cp0   = i_repl;
                o_res.count = 2'd1;
            end
        end else if (i_byte_value <= LEAD2_MAX) begin
            n_pend = PEND_ONE;
            n_acc  = {{(CP_W-5){1'b0}}, i_byte_value[4:0]};
        end else if (i_byte_value <= LEAD3_MAX) begin
            n_pend = PEND_TWO;
            n_acc  = {{(CP_W-4){1'b0}}, i_byte_value[3:0]};
        end else if (i_byte_value <= LEAD4_MAX) begin
            n_pend = PEND_THREE;
            n_acc  = {{(CP_W-3){1'b0}}, i_byte_value[2:0]};
        end else begin
            o_res.cp0   = i_repl;
            o_res.count = 2'd1;
            n_pend      = PEND_NONE;
        end

        if (i_end_of_text) begin
            // truncated sequence at end of text: append the substitute
            if (n_pend != PEND_NONE) begin
                o_res.cp0   = i_repl;
                o_res.count = 2'd1;
            end
            n_pend = PEND_NONE;
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
            r_acc  <= '0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
        end
    end

    assign o_pend_idle = (r_pend == PEND_NONE);

endmodule

[hw/rtl/ubsd_result_buf.sv]
`timescale 1ns / 1ps
// Two-slot result register that drains the code points of one byte in order.
// Uses ubsd_pkg and the ubsd_out_if channel.
module ubsd_result_buf import ubsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_dec_res   i_res,
    output logic       o_load_ready,
    ubsd_out_if.source o_out
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CP_W-1:0]  r_slot0;
    logic [CP_W-1:0]  n_slot0;
    logic [CP_W-1:0]  r_slot1;
    logic [CP_W-1:0]  n_slot1;
    logic             out_fire;

    assign out_fire    = o_out.valid && o_out.ready;
    assign o_load_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (out_fire) begin
            // advance the second slot to the head
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
        if (i_load) begin
            n_cnt   = i_res.count;
            n_slot0 = i_res.cp0;
            n_slot1 = i_res.cp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.code_point  = r_slot0;
    assign o_out.last_of_run = (r_cnt == 2'd1);

endmodule

[hw/rtl/utf8_byte_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// UTF-8 byte stream decoder, top level: config register, decoder, result buffer.
// Depends on ubsd_pkg, ubsd_in_if, ubsd_out_if, ubsd_decoder, ubsd_result_buf.
//
// Usage:
//   i_in  carries one UTF-8 byte per item plus an end_of_text flag on the
//         last byte of a text. o_out carries decoded code points, with
//         last_of_run set on the final code point caused by a byte.
//   i_cfg_we / i_cfg_wdata write the substitute code point (reset value 32);
//   write it only while the block is idle.
// Timing:
//   A byte is classified in the cycle it is accepted; its code points
//   appear on o_out from the next cycle.
//   One byte per cycle is accepted while each byte yields at most one code
//   point and the receiver keeps up; a byte that yields two code points
//   holds the two-slot result register until its second code point is taken.
//   Bytes that only open or extend a sequence yield no item at all.
// Reset: synchronous, active low; clears the pending count, accumulator
//   and result count (emptying the result register), and sets the substitute back to 32.
// Stall: when o_out.ready is low, the result register holds and i_in.ready
//   drops once a result is waiting; nothing is lost or repeated.
module utf8_byte_stream_decoder_unit import ubsd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CP_W-1:0] i_cfg_wdata,
    ubsd_in_if.sink         i_in,
    ubsd_out_if.source      o_out
);

    logic [CP_W-1:0] r_repl;
    logic            in_accept;
    logic            load_ready;
    logic            pend_idle;
    t_dec_res        dec_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= REPL_RESET;
        end else if (i_cfg_we) begin
            r_repl <= i_cfg_wdata;
        end
    end

    assign i_in.ready = load_ready;
    assign in_accept  = i_in.valid && load_ready;

    ubsd_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_byte_value  (i_in.byte_value),
        .i_end_of_text (i_in.end_of_text),
        .i_repl        (r_repl),
        .o_res         (dec_res),
        .o_pend_idle   (pend_idle)
    );

    ubsd_result_buf u_result_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_accept),
        .i_res        (dec_res),
        .o_load_ready (load_ready),
        .o_out        (o_out)
    );

    // A first result that is not last is always followed by the last one
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_run |=> o_out.valid && o_out.last_of_run)
        else $error("second result of a byte missing");

    // End of text leaves no sequence pending
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.end_of_text |=> pend_idle)
        else $error("sequence still pending after end of text");

    // Input backpressure only comes from a waiting result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled without a waiting result");

    // An item that yields nothing leaves the output empty next cycle
    a_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && dec_res.count == 2'd0 |=> !o_out.valid)
        else $error("output valid after a byte with no result");

endmodule
